// File: rtl/quaternion_rotation_unit_assert.svh
// ----------------------------------------------------------------------------
// Quaternion rotation unit assertion macros
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_ROTATION_UNIT_ASSERT_SVH
`define QUATERNION_ROTATION_UNIT_ASSERT_SVH

// Property that must hold at every edge.
`define QRU_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Condition that must be followed by another in the next cycle.
`define QRU_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// File: rtl/qru_pkg.sv
// ----------------------------------------------------------------------------
// Quaternion rotation unit package
// Widths, payload types, operation and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package qru_pkg;

	localparam int WORD_BITS     = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int QUEUE_DEPTH   = 4;
	localparam int QMUL_LAT      = 3;
	localparam int INV_LAT       = WORD_BITS + 6;

	localparam logic [1:0] OPCODE_MUL       = 2'd0;
	localparam logic [1:0] OPCODE_ROT_POINT = 2'd1;
	localparam logic [1:0] OPCODE_ROT_FRAME = 2'd2;

	typedef logic signed [WORD_BITS-1:0] word_t;
	// element 0 is w, then x, y, z
	typedef logic [3:0][WORD_BITS-1:0] quat_t;

	typedef enum logic [1:0] {
		OP_MUL,
		OP_ROT_POINT,
		OP_ROT_FRAME,
		OP_NOP
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_ZERO_NORM = 2'd1,
		ST_SAT       = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0] opcode;
		word_t      q_w;
		word_t      q_x;
		word_t      q_y;
		word_t      q_z;
		word_t      p_w;
		word_t      p_x;
		word_t      p_y;
		word_t      p_z;
	} req_t;

	typedef struct packed {
		word_t   r_w;
		word_t   r_x;
		word_t   r_y;
		word_t   r_z;
		status_t status;
	} rsp_t;

	typedef struct packed {
		op_t   op;
		quat_t q;
		quat_t p;
	} job_t;

	// Hamilton product term signs, [component][term], term i pairs a[i] with b[c^i]
	localparam logic [3:0][3:0] QMUL_NEG = {4'b0100, 4'b0010, 4'b1000, 4'b1110};

endpackage

`default_nettype wire

// File: rtl/qru_front.sv
// ----------------------------------------------------------------------------
// Quaternion rotation unit front end
// Accepts request transactions, decodes the opcode and queues jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module qru_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  qru_pkg::req_t      req,
	output logic               job_valid,
	input  logic               job_pop,
	output qru_pkg::job_t      job
);

	localparam int DEPTH = qru_pkg::QUEUE_DEPTH;
	localparam int PTRW  = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	qru_pkg::job_t fifo_q [DEPTH];
	logic [PTRW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	qru_pkg::job_t job_nx;
	logic push;

	always_comb begin
		case (req.opcode)
			qru_pkg::OPCODE_MUL:       job_nx.op = qru_pkg::OP_MUL;
			qru_pkg::OPCODE_ROT_POINT: job_nx.op = qru_pkg::OP_ROT_POINT;
			qru_pkg::OPCODE_ROT_FRAME: job_nx.op = qru_pkg::OP_ROT_FRAME;
			default:                   job_nx.op = qru_pkg::OP_NOP;
		endcase
		job_nx.q = {req.q_z, req.q_y, req.q_x, req.q_w};
		job_nx.p = {req.p_z, req.p_y, req.p_x, req.p_w};
	end

	assign req_ready = count_q != CW'(DEPTH);
	assign job_valid = count_q != '0;
	assign push      = req_valid && req_ready;
	assign job       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + PTRW'(1);
			if (job_pop)
				rd_ptr_q <= rd_ptr_q + PTRW'(1);
			count_q <= count_q + CW'(push) - CW'(job_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_ptr_q] <= job_nx;
	end

endmodule

`default_nettype wire

// File: rtl/qru_qmul.sv
// ----------------------------------------------------------------------------
// Quaternion rotation unit Hamilton product
// Three stages: products, pair sums, round half up and saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module qru_qmul #(
	parameter int FRAC_BITS = qru_pkg::FRAC_BITS_DEF
) (
	input  logic           clk,
	input  logic           en,
	input  qru_pkg::quat_t a,
	input  qru_pkg::quat_t b,
	output qru_pkg::quat_t r,
	output logic           clip
);

	localparam int W  = qru_pkg::WORD_BITS;
	localparam int PW = 2 * W;
	localparam int SW = PW + 2;
	localparam int RW = SW - FRAC_BITS;
	localparam logic signed [SW-1:0] HALF = SW'(1) <<< (FRAC_BITS - 1);
	localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

	logic signed [PW-1:0] prod_s1 [4][4];
	logic signed [PW:0]   pair_s2 [4][2];
	qru_pkg::quat_t       r_s3;
	logic                 clip_s3;

	logic signed [SW-1:0] tot [4];
	logic signed [RW-1:0] rnd [4];
	logic [3:0] ovfp, ovfn;
	qru_pkg::quat_t sat;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 4; c++) begin
				for (int i = 0; i < 4; i++)
					prod_s1[c][i] <= $signed(a[i]) * $signed(b[2'(c ^ i)]);
				for (int k = 0; k < 2; k++)
					pair_s2[c][k] <=
						(qru_pkg::QMUL_NEG[c][2*k] ? -((PW+1)'(prod_s1[c][2*k]))
							: (PW+1)'(prod_s1[c][2*k])) +
						(qru_pkg::QMUL_NEG[c][2*k+1] ? -((PW+1)'(prod_s1[c][2*k+1]))
							: (PW+1)'(prod_s1[c][2*k+1]));
			end
			r_s3    <= sat;
			clip_s3 <= |(ovfp | ovfn);
		end
	end

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			tot[c]  = SW'(pair_s2[c][0]) + SW'(pair_s2[c][1]) + HALF;
			rnd[c]  = RW'(tot[c] >>> FRAC_BITS);
			ovfp[c] = !rnd[c][RW-1] && (|rnd[c][RW-2:W-1]);
			ovfn[c] = rnd[c][RW-1] && !(&rnd[c][RW-2:W-1]);
			sat[c]  = ovfp[c] ? MAXV : (ovfn[c] ? MINV : rnd[c][W-1:0]);
		end
	end

	assign r    = r_s3;
	assign clip = clip_s3;

endmodule

`default_nettype wire

// File: rtl/qru_inv.sv
// ----------------------------------------------------------------------------
// Quaternion rotation unit inverse
// Squared norm, then conj(q) / norm by a pipelined restoring divider,
// rounded half away from zero and saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module qru_inv #(
	parameter int FRAC_BITS = qru_pkg::FRAC_BITS_DEF
) (
	input  logic           clk,
	input  logic           en,
	input  qru_pkg::quat_t q,
	output qru_pkg::quat_t inv,
	output logic           zero,
	output logic           clip
);

	localparam int W  = qru_pkg::WORD_BITS;
	localparam int PW = 2 * W;
	localparam int SW = PW + 2;
	localparam int NW = SW - FRAC_BITS;
	localparam int QW = W + 1;
	localparam int MW = W + FRAC_BITS;
	localparam int DW = ((NW > MW) ? NW : MW) + 1;
	localparam logic signed [SW-1:0] HALF = SW'(1) <<< (FRAC_BITS - 1);
	localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

	logic signed [PW-1:0] sq_s1 [4];
	logic signed [W:0]    cv_s1 [4];
	logic signed [PW:0]   pair_s2 [2];
	logic signed [W:0]    cv_s2 [4];
	logic [NW-1:0]        n_s3;
	logic signed [W:0]    cv_s3 [4];

	logic [NW-1:0] rem_s [QW][4];
	logic [QW-1:0] dd_s  [QW][4];
	logic [QW-1:0] quo_s [QW+1][4];
	logic [NW-1:0] n_s   [QW];
	logic [3:0]    neg_s [QW+1];
	logic [3:0]    ovf_s [QW+1];
	logic          zero_s [QW+1];

	qru_pkg::quat_t inv_q;
	logic zero_q, clip_q;

	logic signed [SW-1:0] nsum;
	logic signed [W:0]    absv [4];
	logic [DW-1:0]        dd4 [4];
	logic [3:0]           neg4, ovf4;
	logic [NW:0]          trial [QW][4];
	logic [3:0]           ge [QW];
	logic [NW-1:0]        rem_nx [QW][4];
	logic [3:0]           cl;
	qru_pkg::quat_t       inv_nx;

	always_comb begin
		nsum = SW'(pair_s2[0]) + SW'(pair_s2[1]) + HALF;
		for (int i = 0; i < 4; i++) begin
			neg4[i] = cv_s3[i][W];
			absv[i] = neg4[i] ? -cv_s3[i] : cv_s3[i];
			dd4[i]  = DW'({absv[i][W-1:0], {FRAC_BITS{1'b0}}}) + DW'(n_s3 >> 1);
			ovf4[i] = (dd4[i] >> QW) >= DW'(n_s3);
		end
		for (int j = 0; j < QW; j++) begin
			for (int i = 0; i < 4; i++) begin
				trial[j][i]  = {rem_s[j][i], dd_s[j][i][QW-1]};
				ge[j][i]     = trial[j][i] >= {1'b0, n_s[j]};
				rem_nx[j][i] = ge[j][i] ? NW'(trial[j][i] - {1'b0, n_s[j]})
					: NW'(trial[j][i]);
			end
		end
		for (int i = 0; i < 4; i++) begin
			cl[i] = ovf_s[QW][i] | (neg_s[QW][i]
				? (quo_s[QW][i][W] | (quo_s[QW][i][W-1] & (|quo_s[QW][i][W-2:0])))
				: (quo_s[QW][i][W] | quo_s[QW][i][W-1]));
			if (cl[i])
				inv_nx[i] = neg_s[QW][i] ? MINV : MAXV;
			else
				inv_nx[i] = neg_s[QW][i] ? W'(QW'(0) - quo_s[QW][i]) : W'(quo_s[QW][i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				sq_s1[i] <= $signed(q[i]) * $signed(q[i]);
				cv_s1[i] <= (i == 0) ? (W+1)'($signed(q[i])) : -((W+1)'($signed(q[i])));
			end
			for (int k = 0; k < 2; k++)
				pair_s2[k] <= (PW+1)'(sq_s1[2*k]) + (PW+1)'(sq_s1[2*k+1]);
			cv_s2 <= cv_s1;
			n_s3  <= NW'(nsum >>> FRAC_BITS);
			cv_s3 <= cv_s2;

			for (int i = 0; i < 4; i++) begin
				rem_s[0][i] <= NW'(dd4[i] >> QW);
				dd_s[0][i]  <= dd4[i][QW-1:0];
				quo_s[0][i] <= '0;
			end
			n_s[0]    <= n_s3;
			neg_s[0]  <= neg4;
			ovf_s[0]  <= ovf4;
			zero_s[0] <= n_s3 == '0;

			for (int j = 0; j < QW; j++) begin
				for (int i = 0; i < 4; i++) begin
					if (j < QW - 1) begin
						rem_s[j+1][i] <= rem_nx[j][i];
						dd_s[j+1][i]  <= {dd_s[j][i][QW-2:0], 1'b0};
					end
					quo_s[j+1][i] <= {quo_s[j][i][QW-2:0], ge[j][i]};
				end
				if (j < QW - 1)
					n_s[j+1] <= n_s[j];
				neg_s[j+1]  <= neg_s[j];
				ovf_s[j+1]  <= ovf_s[j];
				zero_s[j+1] <= zero_s[j];
			end

			inv_q  <= inv_nx;
			zero_q <= zero_s[QW];
			clip_q <= !zero_s[QW] && (|cl);
		end
	end

	assign inv  = inv_q;
	assign zero = zero_q;
	assign clip = clip_q;

endmodule

`default_nettype wire

// File: rtl/qru_back.sv
// ----------------------------------------------------------------------------
// Quaternion rotation unit back end
// Inverse, two chained Hamilton products and the response register.
// The whole pipeline advances together unless the response is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module qru_back #(
	parameter int FRAC_BITS = qru_pkg::FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	output logic          job_pop,
	input  qru_pkg::job_t job,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output qru_pkg::rsp_t rsp
);

	localparam int W  = qru_pkg::WORD_BITS;
	localparam int LI = qru_pkg::INV_LAT;
	localparam int LM = qru_pkg::QMUL_LAT;
	localparam logic [W-1:0] ONE = W'(1) << FRAC_BITS;
	localparam qru_pkg::quat_t IDENT = {{(3*W){1'b0}}, ONE};

	typedef struct packed {
		qru_pkg::op_t   op;
		qru_pkg::quat_t c;
		logic           zero;
		logic           clip;
	} mid_t;

	typedef struct packed {
		qru_pkg::op_t op;
		logic         zero;
		logic         clip;
	} fin_t;

	logic [LI-1:0]  side_v_s;
	qru_pkg::job_t  side_s [LI];
	logic [LM-1:0]  mid_v_s;
	mid_t           mid_s [LM];
	logic [LM-1:0]  fin_v_s;
	fin_t           fin_s [LM];
	logic           rsp_valid_q;
	qru_pkg::rsp_t  rsp_q;

	logic adv;
	qru_pkg::quat_t inv, a1, b1, c2, pv, t1, r2;
	logic inv_zero, inv_clip, t1_clip, r2_clip, rot;
	mid_t mid_nx;
	fin_t fin_nx;
	qru_pkg::rsp_t rsp_nx;

	assign adv     = !rsp_valid_q || rsp_ready;
	assign job_pop = adv && job_valid;

	qru_inv #(.FRAC_BITS(FRAC_BITS)) u_inv (
		.clk  (clk),
		.en   (adv),
		.q    (job.q),
		.inv  (inv),
		.zero (inv_zero),
		.clip (inv_clip)
	);

	qru_qmul #(.FRAC_BITS(FRAC_BITS)) u_qmul_first (
		.clk  (clk),
		.en   (adv),
		.a    (a1),
		.b    (b1),
		.r    (t1),
		.clip (t1_clip)
	);

	qru_qmul #(.FRAC_BITS(FRAC_BITS)) u_qmul_second (
		.clk  (clk),
		.en   (adv),
		.a    (t1),
		.b    (mid_s[LM-1].c),
		.r    (r2),
		.clip (r2_clip)
	);

	always_comb begin
		pv    = side_s[LI-1].p;
		pv[0] = '0;
		rot   = 1'b1;
		case (side_s[LI-1].op)
			qru_pkg::OP_ROT_POINT: begin
				a1 = side_s[LI-1].q;
				b1 = pv;
				c2 = inv;
			end
			qru_pkg::OP_ROT_FRAME: begin
				a1 = inv;
				b1 = pv;
				c2 = side_s[LI-1].q;
			end
			default: begin
				a1  = side_s[LI-1].q;
				b1  = side_s[LI-1].p;
				c2  = IDENT;
				rot = 1'b0;
			end
		endcase
		mid_nx.op   = side_s[LI-1].op;
		mid_nx.c    = c2;
		mid_nx.zero = inv_zero;
		mid_nx.clip = rot && inv_clip;

		fin_nx.op   = mid_s[LM-1].op;
		fin_nx.zero = mid_s[LM-1].zero;
		fin_nx.clip = mid_s[LM-1].clip || t1_clip;
	end

	always_comb begin
		rsp_nx.r_w    = '0;
		rsp_nx.r_x    = '0;
		rsp_nx.r_y    = '0;
		rsp_nx.r_z    = '0;
		rsp_nx.status = qru_pkg::ST_OK;
		case (fin_s[LM-1].op)
			qru_pkg::OP_MUL: begin
				rsp_nx.r_w = r2[0];
				rsp_nx.r_x = r2[1];
				rsp_nx.r_y = r2[2];
				rsp_nx.r_z = r2[3];
				if (fin_s[LM-1].clip || r2_clip)
					rsp_nx.status = qru_pkg::ST_SAT;
			end
			qru_pkg::OP_ROT_POINT, qru_pkg::OP_ROT_FRAME: begin
				if (fin_s[LM-1].zero) begin
					rsp_nx.status = qru_pkg::ST_ZERO_NORM;
				end else begin
					rsp_nx.r_x = r2[1];
					rsp_nx.r_y = r2[2];
					rsp_nx.r_z = r2[3];
					if (fin_s[LM-1].clip || r2_clip)
						rsp_nx.status = qru_pkg::ST_SAT;
				end
			end
			default: begin
				rsp_nx.status = qru_pkg::ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_v_s    <= '0;
			mid_v_s     <= '0;
			fin_v_s     <= '0;
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			side_v_s    <= {side_v_s[LI-2:0], job_valid};
			mid_v_s     <= {mid_v_s[LM-2:0], side_v_s[LI-1]};
			fin_v_s     <= {fin_v_s[LM-2:0], mid_v_s[LM-1]};
			rsp_valid_q <= fin_v_s[LM-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s[0] <= job;
			for (int k = 1; k < LI; k++)
				side_s[k] <= side_s[k-1];
			mid_s[0] <= mid_nx;
			fin_s[0] <= fin_nx;
			for (int k = 1; k < LM; k++) begin
				mid_s[k] <= mid_s[k-1];
				fin_s[k] <= fin_s[k-1];
			end
			rsp_q <= rsp_nx;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

// File: rtl/quaternion_rotation_unit.sv
// ----------------------------------------------------------------------------
// Quaternion rotation unit
// Q16.16 Hamilton product, point rotation and frame rotation.
//
//   channel   signals                      direction   payload
//   req       req_valid req_ready req      in          qru_pkg::req_t
//   rsp       rsp_valid rsp_ready rsp      out         qru_pkg::rsp_t
//
// One transaction per cycle in each direction when rsp_ready stays high.
// The back pipeline is the one bit per stage divider that forms the inverse,
// followed by two three-stage products and the response register.
// A four-entry job queue sits in front; a stalled response freezes the
// whole back pipeline and req_ready falls once the queue fills.
// arst_n clears all valid state; data registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_rotation_unit #(
	parameter int FRAC_BITS = qru_pkg::FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  qru_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output qru_pkg::rsp_t rsp
);

	logic          job_valid, job_pop;
	qru_pkg::job_t job;

	qru_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.job_valid (job_valid),
		.job_pop   (job_pop),
		.job       (job)
	);

	qru_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job_pop   (job_pop),
		.job       (job),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

// File: rtl/qru_checker.sv
// ----------------------------------------------------------------------------
// Quaternion rotation unit checker
// Port level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "quaternion_rotation_unit_assert.svh"

module qru_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_ready,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input qru_pkg::rsp_t rsp
);

	logic rsp_zero_norm;
	logic rsp_cleared;

	assign rsp_zero_norm = rsp_valid && rsp.status == qru_pkg::ST_ZERO_NORM;
	assign rsp_cleared   = rsp.r_w == '0 && rsp.r_x == '0 && rsp.r_y == '0 && rsp.r_z == '0;

	`QRU_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "rsp transaction dropped")
	`QRU_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp), "rsp changed in stall")
	`QRU_ASSERT(a_zero_norm_clear, rsp_zero_norm |-> rsp_cleared, "zero norm result not cleared")
	`QRU_ASSERT(a_full_on_stall, $fell(req_ready) |-> $past(rsp_valid && !rsp_ready), "queue filled without stall")

endmodule

bind quaternion_rotation_unit qru_checker u_qru_checker (.*);

`default_nettype wire

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// Quaternion rotation unit testbench
// Drives product, point rotation, frame rotation and no-op transactions under
// varying source idle and sink stall rates. Each accepted response is checked
// field by field against an in-order queue of results from a local predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

	localparam int FRAC = 16;
	localparam int DRAIN_CYCLES = 80;

	typedef logic signed [79:0] wide_t;
	typedef qru_pkg::word_t quat_v [4];

	logic           clk;
	logic           arst_n;
	logic           req_valid;
	logic           req_ready;
	qru_pkg::req_t  req;
	logic           rsp_valid;
	logic           rsp_ready;
	qru_pkg::rsp_t  rsp;

	qru_pkg::rsp_t expected_rsp [$];
	int   mismatches = 0;
	int   idle_pct = 0;
	int   stall_pct = 0;

	quaternion_rotation_unit dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("Mismatches found");
		$finish;
	end

	// -------- predictor --------
	function automatic wide_t round_frac(input wide_t s);
		return (s + (wide_t'(1) <<< (FRAC - 1))) >>> FRAC;
	endfunction

	function automatic qru_pkg::word_t clamp_word(input wide_t v, inout bit clip);
		if (v > wide_t'(32'sh7fffffff)) begin
			clip = 1'b1;
			return 32'sh7fffffff;
		end
		if (v < -wide_t'(64'sh80000000)) begin
			clip = 1'b1;
			return 32'sh80000000;
		end
		return qru_pkg::word_t'(v);
	endfunction

	function automatic quat_v quat_product(input quat_v a, input quat_v b, inout bit clip);
		wide_t aw, ax, ay, az, bw, bx, by, bz;
		quat_v r;
		aw = a[0]; ax = a[1]; ay = a[2]; az = a[3];
		bw = b[0]; bx = b[1]; by = b[2]; bz = b[3];
		r[0] = clamp_word(round_frac(aw*bw - ax*bx - ay*by - az*bz), clip);
		r[1] = clamp_word(round_frac(aw*bx + ax*bw + ay*bz - az*by), clip);
		r[2] = clamp_word(round_frac(aw*by - ax*bz + ay*bw + az*bx), clip);
		r[3] = clamp_word(round_frac(aw*bz + ax*by - ay*bx + az*bw), clip);
		return r;
	endfunction

	function automatic wide_t div_half_away(input wide_t num, input wide_t den);
		wide_t mag;
		wide_t qv;
		mag = (num < 0) ? -num : num;
		qv = (mag + den / 2) / den;
		return (num < 0) ? -qv : qv;
	endfunction

	function automatic qru_pkg::rsp_t predict_result(input qru_pkg::req_t x);
		quat_v q, p, inv, t, r;
		wide_t n;
		bit clip;
		qru_pkg::rsp_t o;
		clip = 1'b0;
		q = '{x.q_w, x.q_x, x.q_y, x.q_z};
		p = '{x.p_w, x.p_x, x.p_y, x.p_z};
		r = '{0, 0, 0, 0};
		o.status = qru_pkg::ST_OK;
		case (qru_pkg::op_t'(x.opcode))
			qru_pkg::OP_MUL: begin
				r = quat_product(q, p, clip);
				if (clip) o.status = qru_pkg::ST_SAT;
			end
			qru_pkg::OP_ROT_POINT, qru_pkg::OP_ROT_FRAME: begin
				n = round_frac(wide_t'(q[0])*q[0] + wide_t'(q[1])*q[1]
					+ wide_t'(q[2])*q[2] + wide_t'(q[3])*q[3]);
				if (n <= 0) begin
					o.status = qru_pkg::ST_ZERO_NORM;
				end else begin
					inv[0] = clamp_word(div_half_away(wide_t'(q[0]) <<< FRAC, n), clip);
					inv[1] = clamp_word(div_half_away(-(wide_t'(q[1]) <<< FRAC), n), clip);
					inv[2] = clamp_word(div_half_away(-(wide_t'(q[2]) <<< FRAC), n), clip);
					inv[3] = clamp_word(div_half_away(-(wide_t'(q[3]) <<< FRAC), n), clip);
					p[0] = '0;
					if (qru_pkg::op_t'(x.opcode) == qru_pkg::OP_ROT_POINT) begin
						t = quat_product(q, p, clip);
						r = quat_product(t, inv, clip);
					end else begin
						t = quat_product(inv, p, clip);
						r = quat_product(t, q, clip);
					end
					r[0] = '0;
					if (clip) o.status = qru_pkg::ST_SAT;
				end
			end
			default: ;
		endcase
		o.r_w = r[0]; o.r_x = r[1]; o.r_y = r[2]; o.r_z = r[3];
		return o;
	endfunction

	// -------- response check --------
	always @(negedge clk) begin
		rsp_ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		qru_pkg::rsp_t e;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_rsp.size() == 0) begin
				$display("%0t unexpected response %h", $time, rsp);
				mismatches++;
			end else begin
				e = expected_rsp.pop_front();
				if (rsp.r_w !== e.r_w)
					$display("%0t r_w exp %h got %h", $time, e.r_w, rsp.r_w);
				if (rsp.r_x !== e.r_x)
					$display("%0t r_x exp %h got %h", $time, e.r_x, rsp.r_x);
				if (rsp.r_y !== e.r_y)
					$display("%0t r_y exp %h got %h", $time, e.r_y, rsp.r_y);
				if (rsp.r_z !== e.r_z)
					$display("%0t r_z exp %h got %h", $time, e.r_z, rsp.r_z);
				if (rsp.status !== e.status)
					$display("%0t status exp %0d got %0d", $time, e.status, rsp.status);
				if (rsp !== e) mismatches++;
			end
		end
	end

	// -------- stimulus --------
	task automatic send_req(input qru_pkg::req_t x);
		@(negedge clk);
		req <= x;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		expected_rsp.push_back(predict_result(x));
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			req_valid <= 1'b0;
		end
	endtask

	function automatic qru_pkg::word_t any_word();
		case ($urandom_range(4))
			0: return $urandom;
			1: return $urandom_range(3) == 0 ? 32'sh7fffffff : 32'sh80000000;
			2: return qru_pkg::word_t'($signed($urandom_range(2000)) - 1000);
			default: return qru_pkg::word_t'($signed($urandom_range(1 << 21)) - (1 << 20));
		endcase
	endfunction

	function automatic qru_pkg::word_t unit_word();
		return qru_pkg::word_t'($signed($urandom_range(140000)) - 70000);
	endfunction

	function automatic qru_pkg::req_t make_req(input qru_pkg::op_t op, input bit wellformed);
		qru_pkg::req_t x;
		x.opcode = op;
		if (wellformed) begin
			x.q_w = unit_word(); x.q_x = unit_word();
			x.q_y = unit_word(); x.q_z = unit_word();
		end else begin
			x.q_w = any_word(); x.q_x = any_word();
			x.q_y = any_word(); x.q_z = any_word();
		end
		x.p_w = any_word(); x.p_x = any_word();
		x.p_y = any_word(); x.p_z = any_word();
		return x;
	endfunction

	task automatic test_directed();
		qru_pkg::req_t x;
		qru_pkg::op_t op;
		for (int k = 0; k < 3; k++) begin
			op = qru_pkg::op_t'(k);
			x = '{op, 32'sh10000, 0, 0, 0, 32'sh10000, 32'sh20000, -32'sh30000, 32'sh8000};
			send_req(x);
			x = '{op, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
				32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000};
			send_req(x);
			x = '{op, 0, 0, 0, 0, 32'sh10000, 32'sh10000, 32'sh10000, 32'sh10000};
			send_req(x);
			x = '{op, 1, 0, 0, 1, 5, 6, 7, 8};
			send_req(x);
			x = '{op, 8, 0, 0, 0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
				32'sh7fffffff};
			send_req(x);
			x = '{op, -32'sh5a82, 32'sh5a82, -1, -1, -1, -1, -1, -1};
			send_req(x);
		end
		x = '{qru_pkg::OP_NOP, -1, -1, -1, -1, -1, -1, -1, -1};
		send_req(x);
		x = '{qru_pkg::OP_NOP, 32'sh12345678, 0, 0, 0, 0, 0, 0, 0};
		send_req(x);
	endtask

	task automatic test_multiply(input int count);
		repeat (count) send_req(make_req(qru_pkg::OP_MUL, $urandom_range(1)));
	endtask

	task automatic test_rotate_point(input int count);
		repeat (count) send_req(make_req(qru_pkg::OP_ROT_POINT, $urandom_range(9) < 8));
	endtask

	task automatic test_rotate_frame(input int count);
		repeat (count) send_req(make_req(qru_pkg::OP_ROT_FRAME, $urandom_range(9) < 8));
	endtask

	task automatic test_mixed(input int count);
		repeat (count)
			send_req(make_req(qru_pkg::op_t'($urandom_range(3)), $urandom_range(1)));
	endtask

	initial begin
		int idle_set [4];
		int stall_set [4];
		idle_set = '{0, 65, 0, 21};
		stall_set = '{0, 0, 65, 21};
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_ready = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = idle_set[ph];
			stall_pct = stall_set[ph];
			test_multiply(100);
			test_rotate_point(110);
			test_rotate_frame(110);
			test_mixed(50);
		end
		@(negedge clk);
		req_valid <= 1'b0;
		while (expected_rsp.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

`default_nettype wire

// File: files.f
+incdir+rtl
rtl/qru_pkg.sv
rtl/qru_front.sv
rtl/qru_qmul.sv
rtl/qru_inv.sv
rtl/qru_back.sv
rtl/quaternion_rotation_unit.sv
rtl/qru_checker.sv
dv/tb.sv
